/* rtl/deque_with_key_delete_top_defines.svh */
// Assertion macros used by the deque control logic.
`ifndef DEQUE_WITH_KEY_DELETE_TOP_DEFINES_SVH
`define DEQUE_WITH_KEY_DELETE_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define DWKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next.
`define DWKD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/dwkd_pkg.sv */
// Types and codes for the double-ended record queue.
`default_nettype none

package dwkd_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_BACK   = 3'd1,
    OP_POP_FRONT   = 3'd2,
    OP_POP_BACK    = 3'd3,
    OP_DELETE_YEAR = 3'd4
  } op_e_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_POP  = 2'd1,
    ST_DEL  = 2'd2
  } state_t;

  typedef struct packed {
    logic [15:0] year;
    logic [31:0] tag;
    logic [31:0] size;
  } rec_t;

  typedef struct packed {
    logic [15:0] year;
    logic [31:0] tag;
    logic [31:0] size;
    logic        was_empty;
    logic        was_full;
    logic [6:0]  removed;
    logic [6:0]  entries;
  } res_t;

endpackage

`default_nettype wire

/* rtl/dwkd_mem.sv */
// Record store: one write port, one registered read port.
`default_nettype none

module dwkd_mem
  import dwkd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire rec_t          wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output rec_t               rd_data
);

  rec_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/dwkd_ctrl.sv */
// Queue control: head/count bookkeeping, pop sequencing, delete compaction.
`default_nettype none
`include "deque_with_key_delete_top_defines.svh"

module dwkd_ctrl
  import dwkd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    in_operation,
  input  wire logic [15:0]   in_year_value,
  input  wire logic [31:0]   in_name_tag,
  input  wire logic [31:0]   in_size_word,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [15:0]        out_year,
  output logic [31:0]        out_tag,
  output logic [31:0]        out_size,
  output logic               out_was_empty,
  output logic               out_was_full,
  output logic [6:0]         out_removed_count,
  output logic [6:0]         out_entry_count,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output rec_t               mem_wr_data,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr,
  input  wire rec_t          mem_rd_data
);

  localparam int AW1 = AW + 1;
  localparam logic [AW:0]   DEPTH_X = AW1'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] cmp_off_r, cmp_off_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [15:0]   key_r, key_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          res_r, res_nxt;

  op_e_t         op;
  logic          accept;
  logic          full_now;
  logic          last;
  logic          hit;
  logic [CW-1:0] kept_inc;

  // (head + offset) mod DEPTH, offset below DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, off[AW-1:0]};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [6:0] cnt7(input logic [CW-1:0] c);
    logic [CW+6:0] t;
    t = {7'b0, c};
    return t[6:0];
  endfunction

  assign op       = op_e_t'(in_operation);
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full_now = (held_r == DEPTH_C);
  assign last     = (cmp_off_r == held_r - CW'(1));
  assign hit      = (mem_rd_data.year == key_r);
  assign kept_inc = hit ? kept_r : kept_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    held_nxt      = held_r;
    cmp_off_nxt   = cmp_off_r;
    kept_nxt      = kept_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = head_r;
    mem_wr_data   = '{year: in_year_value, tag: in_name_tag, size: in_size_word};
    mem_rd_en     = 1'b0;
    mem_rd_addr   = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          unique case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (full_now) begin
                res_nxt.was_full = 1'b1;
                res_nxt.entries  = cnt7(held_r);
              end else begin
                mem_wr_en = 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  head_nxt    = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
                  mem_wr_addr = head_nxt;
                end else begin
                  mem_wr_addr = slot_of(head_r, held_r);
                end
                held_nxt        = held_r + CW'(1);
                res_nxt.entries = cnt7(held_nxt);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (held_r == '0) begin
                out_valid_nxt     = 1'b1;
                res_nxt.was_empty = 1'b1;
              end else begin
                mem_rd_en = 1'b1;
                if (op == OP_POP_FRONT) begin
                  mem_rd_addr = head_r;
                  head_nxt    = slot_of(head_r, CW'(1));
                end else begin
                  mem_rd_addr = slot_of(head_r, held_r - CW'(1));
                end
                held_nxt  = held_r - CW'(1);
                state_nxt = ST_POP;
              end
            end
            OP_DELETE_YEAR: begin
              if (held_r == '0) begin
                out_valid_nxt     = 1'b1;
                res_nxt.was_empty = 1'b1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = head_r;
                key_nxt     = in_year_value;
                cmp_off_nxt = '0;
                kept_nxt    = '0;
                state_nxt   = ST_DEL;
              end
            end
            default: begin
              out_valid_nxt   = 1'b1;
              res_nxt.entries = cnt7(held_r);
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt   = 1'b1;
        res_nxt         = '0;
        res_nxt.year    = mem_rd_data.year;
        res_nxt.tag     = mem_rd_data.tag;
        res_nxt.size    = mem_rd_data.size;
        res_nxt.entries = cnt7(held_r);
        state_nxt       = ST_IDLE;
      end
      ST_DEL: begin
        // read of the next record overlaps the compare of this one; the
        // write slot trails the read slot, so no forwarding is needed
        if (!last) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = slot_of(head_r, cmp_off_r + CW'(1));
        end
        if (!hit) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = slot_of(head_r, kept_r);
          mem_wr_data = mem_rd_data;
        end
        kept_nxt    = kept_inc;
        cmp_off_nxt = cmp_off_r + CW'(1);
        if (last) begin
          held_nxt        = kept_inc;
          out_valid_nxt   = 1'b1;
          res_nxt         = '0;
          res_nxt.removed = cnt7(held_r - kept_inc);
          res_nxt.entries = cnt7(kept_inc);
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_off_r <= cmp_off_nxt;
    kept_r    <= kept_nxt;
    key_r     <= key_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_year          = res_r.year;
  assign out_tag           = res_r.tag;
  assign out_size          = res_r.size;
  assign out_was_empty     = res_r.was_empty;
  assign out_was_full      = res_r.was_full;
  assign out_removed_count = res_r.removed;
  assign out_entry_count   = res_r.entries;

  `DWKD_ASSERT(a_held_bound, held_r <= DEPTH_C, "held count above depth")
  `DWKD_ASSERT(a_kept_trails, (state_r != ST_DEL) || (kept_r <= cmp_off_r),
               "write slot ahead of scan")
  `DWKD_ASSERT(a_del_read, (state_r != ST_DEL) || $past(mem_rd_en), "compare without a read")
  `DWKD_ASSERT_NEXT(a_push_count,
                    accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !full_now,
                    held_r == $past(held_r) + CW'(1), "push did not grow count")

endmodule

`default_nettype wire

/* rtl/deque_with_key_delete_top.sv */
// Bounded double-ended record queue: push/pop at both ends, delete by year key.
// Push and every operation that meets an empty or full queue registers its
// result in the cycle after it is taken. A pop issues the synchronous read of
// the record store when taken and registers the record in ST_POP. Delete by
// year reads the first held record when taken, then in ST_DEL streams the held
// records through the single read port one per cycle while kept records are
// written back compacted; the last compare registers the result. One item is
// in work at a time; a new item is taken once the block is idle and the output
// register is free or being read. The store needs no clearing after reset.
`default_nettype none

module deque_with_key_delete_top
  import dwkd_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [15:0] in_year_value,
  input  wire logic [31:0] in_name_tag,
  input  wire logic [31:0] in_size_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_year,
  output logic [31:0]      out_tag,
  output logic [31:0]      out_size,
  output logic             out_was_empty,
  output logic             out_was_full,
  output logic [6:0]       out_removed_count,
  output logic [6:0]       out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  rec_t          rd_data;

  dwkd_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_year_value    (in_year_value),
    .in_name_tag      (in_name_tag),
    .in_size_word     (in_size_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_tag          (out_tag),
    .out_size         (out_size),
    .out_was_empty    (out_was_empty),
    .out_was_full     (out_was_full),
    .out_removed_count(out_removed_count),
    .out_entry_count  (out_entry_count),
    .mem_wr_en        (wr_en),
    .mem_wr_addr      (wr_addr),
    .mem_wr_data      (wr_data),
    .mem_rd_en        (rd_en),
    .mem_rd_addr      (rd_addr),
    .mem_rd_data      (rd_data)
  );

  dwkd_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

`default_nettype wire
